/* rtl/chm_pkg.sv */
package chm_pkg;

  localparam int unsigned BUCKETS_DEF = 256;
  localparam int unsigned ENTRIES_DEF = 1024;
  localparam int unsigned CFG_W       = 9;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_KEY_ZERO  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
    logic        [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
    logic [10:0] entry_count;
    logic        is_empty;
  } out_item_t;

endpackage

/* rtl/chm_bucket_mod.sv */
module chm_bucket_mod #(
  parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               key,
  input  logic [chm_pkg::CFG_W-1:0] bucket_count,
  output logic                      done,
  output logic [BW-1:0]             bucket
);

  localparam int unsigned NW = chm_pkg::CFG_W;

  logic [31:0]   h_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] rem_nxt;
  logic [2:0]    cnt_r;
  logic          run_r;
  logic          done_r;
  logic [NW-1:0] n_eff;
  logic [31:0]   prod;
  logic [BW+NW-1:0] rem_ext;

  // Clamp the configured count to the range 1 .. BUCKETS.
  always_comb begin
    if (bucket_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(bucket_count) > 32'(BUCKETS)) begin
      n_eff = NW'(BUCKETS);
    end else begin
      n_eff = bucket_count;
    end
  end

  // Only the low 32 bits of the product feed the hash.
  assign prod = key * chm_pkg::HASH_MUL;

  // Four restoring remainder steps per cycle, covering all 32 hash bits.
  always_comb begin
    logic [NW:0] r;
    r = {1'b0, rem_r};
    for (int i = 0; i < 4; i++) begin
      r = {r[NW-1:0], h_r[31-i]};
      if (r >= {1'b0, n_r}) begin
        r = r - {1'b0, n_r};
      end
    end
    rem_nxt = r[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        h_r   <= prod;
        n_r   <= n_eff;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        h_r   <= {h_r[27:0], 4'b0};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rem_ext = {{BW{1'b0}}, rem_r};
  assign bucket  = rem_ext[BW-1:0];
  assign done    = done_r;

endmodule

/* rtl/chained_hash_map_engine_core.sv */
// Hash map engine with separate chaining. An operation is taken when start is high and
// busy is low; its single result appears on out_item with out_valid high for one cycle,
// and must be taken then. A key operation passes through hashing (the multiply at
// acceptance, remainder steps of four bits each, one hand-off), a read of the bucket head,
// a read of each chain entry visited in the entry memory, one more check when the chain
// ends without the key, any write-back, a registered result and the output. A rejected
// key skips the hash and goes straight to the result. Clear sweeps the bucket head memory
// one bucket per cycle. After reset the same sweep runs with busy high; configuration
// writes are taken at any time.
module chained_hash_map_engine_core #(
  parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
  parameter int unsigned ENTRIES = chm_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  chm_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output chm_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [chm_pkg::CFG_W-1:0] cfg_bucket_count
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = 64 + LW;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_HASH, S_HEAD, S_HGOT, S_ERD, S_ECHK,
    S_FRD, S_FGOT, S_INS, S_REM2, S_DONE
  } state_t;

  state_t                    state_r;
  logic [chm_pkg::CFG_W-1:0] bc_r;
  chm_pkg::op_t              op_r;
  logic [31:0]               key_r;
  logic [31:0]               val_r;
  chm_pkg::status_t          status_r;
  logic [31:0]               found_r;
  logic [BW-1:0]             bucket_r;
  logic [BW-1:0]             clr_r;
  logic                      clr_out_r;
  logic [LW-1:0]             cur_r;
  logic [LW-1:0]             prev_r;
  logic [LW-1:0]             head_r;
  logic [WW-1:0]             prev_word_r;
  logic [LW-1:0]             free_head_r;
  logic [LW-1:0]             wm_r;
  logic [LW-1:0]             held_r;
  logic                      out_valid_r;
  chm_pkg::out_item_t        out_item_r;

  logic [LW-1:0] heads [BUCKETS];
  logic [WW-1:0] ents  [ENTRIES];
  logic [LW-1:0] hd_q;
  logic [WW-1:0] ent_q;

  logic          m_start;
  logic          m_done;
  logic [BW-1:0] m_bucket;

  logic          h_we;
  logic [BW-1:0] h_wa;
  logic [LW-1:0] h_wd;
  logic          e_we;
  logic [LW-1:0] e_wa;
  logic [WW-1:0] e_wd;

  logic          hit;
  logic [LW+10:0] held_ext;

  assign m_start = (state_r == S_IDLE) && start && (in_item.op != chm_pkg::OP_CLEAR) &&
                   (in_item.key != '0);

  chm_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (m_start),
    .key          (in_item.key),
    .bucket_count (bc_r),
    .done         (m_done),
    .bucket       (m_bucket)
  );

  assign hit = (ent_q[WW-1 -: 32] == key_r);

  // Memory write port selection.
  always_comb begin
    h_we = 1'b0;
    h_wa = bucket_r;
    h_wd = cur_r;
    e_we = 1'b0;
    e_wa = cur_r;
    e_wd = {key_r, val_r, head_r};
    case (state_r)
      S_CLR: begin
        h_we = 1'b1;
        h_wa = clr_r;
        h_wd = NIL;
      end
      S_INS: begin
        h_we = 1'b1;
        e_we = 1'b1;
      end
      S_ECHK: begin
        if (hit && op_r == chm_pkg::OP_INSERT) begin
          e_we = 1'b1;
          e_wd = {key_r, val_r, ent_q[LW-1:0]};
        end else if (hit && op_r == chm_pkg::OP_REMOVE) begin
          if (prev_r != NIL) begin
            e_we = 1'b1;
            e_wa = prev_r;
            e_wd = {prev_word_r[WW-1:LW], ent_q[LW-1:0]};
          end else begin
            h_we = 1'b1;
            h_wd = ent_q[LW-1:0];
          end
        end
      end
      S_REM2: begin
        e_we = 1'b1;
        e_wd = {64'd0, free_head_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heads[h_wa] <= h_wd;
    end
    hd_q <= heads[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      ents[e_wa[EW-1:0]] <= e_wd;
    end
    ent_q <= ents[cur_r[EW-1:0]];
  end

  assign held_ext = {11'd0, held_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_out_r   <= 1'b0;
      free_head_r <= NIL;
      wm_r        <= '0;
      held_r      <= '0;
      bc_r        <= chm_pkg::BUCKET_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        bc_r <= cfg_bucket_count;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_item.op;
            key_r    <= in_item.key;
            val_r    <= in_item.value;
            status_r <= chm_pkg::ST_OK;
            found_r  <= '0;
            if (in_item.op == chm_pkg::OP_CLEAR) begin
              free_head_r <= NIL;
              wm_r        <= '0;
              held_r      <= '0;
              clr_r       <= '0;
              clr_out_r   <= 1'b1;
              state_r     <= S_CLR;
            end else if (in_item.key == '0) begin
              status_r <= chm_pkg::ST_KEY_ZERO;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_CLR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == BW'(BUCKETS - 1)) begin
            state_r <= clr_out_r ? S_DONE : S_IDLE;
          end
        end
        S_HASH: begin
          if (m_done) begin
            bucket_r <= m_bucket;
            state_r  <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_r <= S_HGOT;
        end
        S_HGOT: begin
          cur_r   <= hd_q;
          head_r  <= hd_q;
          prev_r  <= NIL;
          state_r <= S_ERD;
        end
        S_ERD: begin
          if (cur_r == NIL) begin
            if (op_r == chm_pkg::OP_INSERT) begin
              if (held_r == NIL) begin
                status_r <= chm_pkg::ST_FULL;
                state_r  <= S_DONE;
              end else if (free_head_r != NIL) begin
                cur_r   <= free_head_r;
                state_r <= S_FRD;
              end else begin
                // Slots at and above the watermark have not been used since the last clear.
                cur_r   <= wm_r;
                wm_r    <= wm_r + LW'(1);
                state_r <= S_INS;
              end
            end else begin
              status_r <= chm_pkg::ST_NOT_FOUND;
              state_r  <= S_DONE;
            end
          end else begin
            state_r <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (hit) begin
            case (op_r)
              chm_pkg::OP_LOOKUP: begin
                found_r <= ent_q[LW +: 32];
                state_r <= S_DONE;
              end
              chm_pkg::OP_REMOVE: begin
                state_r <= S_REM2;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end else begin
            prev_r      <= cur_r;
            prev_word_r <= ent_q;
            cur_r       <= ent_q[LW-1:0];
            state_r     <= S_ERD;
          end
        end
        S_FRD: begin
          state_r <= S_FGOT;
        end
        S_FGOT: begin
          free_head_r <= ent_q[LW-1:0];
          state_r     <= S_INS;
        end
        S_INS: begin
          held_r  <= held_r + LW'(1);
          state_r <= S_DONE;
        end
        S_REM2: begin
          free_head_r <= cur_r;
          if (held_r != '0) begin
            held_r <= held_r - LW'(1);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r             <= 1'b1;
          out_item_r.status       <= status_r;
          out_item_r.found_value  <= found_r;
          out_item_r.entry_count  <= held_ext[10:0];
          out_item_r.is_empty     <= (held_r == '0);
          state_r                 <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.is_empty == (out_item.entry_count == 11'd0)))
    else $error("is_empty disagrees with entry_count");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= NIL)
    else $error("entry count above pool size");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result without completed transaction");
`endif

endmodule
